// File: rtl/lsh_pkg.sv
// Shared types, widths and constants of the 3x3 Laplacian sharpening block.
// No dependencies; every other rtl file imports this package.
package lsh_pkg;

  localparam int CH_W       = 8;
  localparam int NCH        = 3;
  localparam int PIX_W      = CH_W * NCH;
  localparam int SUM_W      = 11;
  localparam int STR_W      = 6;
  localparam int SIDE_W     = 3;
  localparam int CTRW_W     = 6;
  localparam int PROD_W     = 14;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int CNT_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Reciprocal of nine as 57 / 512; exact floor for every 6-bit strength
  localparam int RECIP_9  = 57;
  localparam int RECIP_SH = 9;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd1024;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd682;
  localparam logic [STR_W-1:0]    STR_RST    = 6'd9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_STRENGTH = 2'd2
  } cfg_idx_e;

  // Window taps of one item, reduced per channel, plus its control flags
  typedef struct packed {
    logic                       emit;
    logic                       last;
    logic [NCH-1:0][SUM_W-1:0]  nsum;
    logic [NCH-1:0][CH_W-1:0]   ctr;
  } taps_t;

  // Surround weight magnitude: floor(k / 9)
  function automatic logic [SIDE_W-1:0] side_weight(input logic [STR_W-1:0] k);
    logic [STR_W+6-1:0] p;
    p = (STR_W + 6)'(k) * (STR_W + 6)'(RECIP_9);
    return p[RECIP_SH +: SIDE_W];
  endfunction

  // Centre weight: 1 + floor(8k / 9)
  function automatic logic [CTRW_W-1:0] centre_weight(input logic [STR_W-1:0] k);
    logic [STR_W+9-1:0] p;
    logic [CTRW_W-1:0]  q;
    p = (STR_W + 9)'({k, 3'b000}) * (STR_W + 9)'(RECIP_9);
    q = p[RECIP_SH +: CTRW_W];
    return q + CTRW_W'(1);
  endfunction

endpackage

// File: rtl/lsh_line_buf.sv
// One row of pixels: simple dual-port memory with registered read data.
// Uses lsh_pkg for the pixel width; a write to the address being read passes through.
module lsh_line_buf #(
  parameter int Depth = 1024,
  parameter int AddrW = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [lsh_pkg::PIX_W-1:0] wdata_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [lsh_pkg::PIX_W-1:0] rdata_o
);
  import lsh_pkg::*;

  logic [PIX_W-1:0] mem_q [Depth];
  logic [PIX_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, new data forwarded on an address match
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lsh_window.sv
// Front end: raster counters, two line buffers and the 3x3 window registers.
// Depends on lsh_pkg and lsh_line_buf; hands per-channel tap sums to the lanes.
module lsh_window #(
  parameter int MaxWidth = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [lsh_pkg::CH_W-1:0]      in_blue_i,
  input  logic [lsh_pkg::CH_W-1:0]      in_green_i,
  input  logic [lsh_pkg::CH_W-1:0]      in_red_i,
  input  logic                          drain_i,
  input  logic [lsh_pkg::WIDTH_W-1:0]   width_i,
  input  logic [lsh_pkg::HEIGHT_W-1:0]  height_i,
  output lsh_pkg::taps_t                taps_o
);
  import lsh_pkg::*;

  localparam int CW = $clog2(MaxWidth);

  logic [CW-1:0]    col_q, col_d;
  logic [CNT_W-1:0] row_q, row_d;
  logic [2:0][PIX_W-1:0] left_q, left_d, ctr_q, ctr_d, right;

  logic [CNT_W-1:0] w_nz, w_eff, h_eff, col_inc;
  logic             last, emit, col_zero;
  logic [PIX_W-1:0] up_rd, mid_rd, up, mid, px;

  // Effective frame size: zero acts as one, width capped at the buffer depth
  always_comb begin
    w_nz  = (width_i == '0) ? CNT_W'(1) : CNT_W'(width_i);
    w_eff = (w_nz > CNT_W'(MaxWidth)) ? CNT_W'(MaxWidth) : w_nz;
    h_eff = (height_i == '0) ? CNT_W'(1) : CNT_W'(height_i);
  end

  assign col_zero = (col_q == '0);
  assign col_inc  = CNT_W'(col_q) + CNT_W'(1);
  assign last     = col_zero && ({1'b0, row_q} >= ({1'b0, h_eff} + (CNT_W + 1)'(1)));
  assign emit     = (row_q >= CNT_W'(2)) || ((row_q == CNT_W'(1)) && !col_zero);

  // Incoming pixel and the two rows above it, masked at the frame borders
  always_comb begin
    px  = (drain_i || (row_q >= h_eff)) ? '0 : {in_red_i, in_green_i, in_blue_i};
    up  = (row_q >= CNT_W'(2)) ? up_rd  : '0;
    mid = (row_q >= CNT_W'(1)) ? mid_rd : '0;
    right[0] = col_zero ? '0 : up;
    right[1] = col_zero ? '0 : mid;
    right[2] = col_zero ? '0 : px;
  end

  // Next counters and window columns
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    left_d = left_q;
    ctr_d  = ctr_q;
    if (accept_i) begin
      if (last) begin
        col_d  = '0;
        row_d  = '0;
        left_d = '0;
        ctr_d  = '0;
      end else begin
        left_d = col_zero ? '0 : ctr_q;
        ctr_d  = {px, mid, up};
        if (col_inc >= w_eff) begin
          col_d = '0;
          row_d = row_q + CNT_W'(1);
        end else begin
          col_d = col_inc[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
      ctr_q  <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      left_q <= left_d;
      ctr_q  <= ctr_d;
    end
  end

  // Line buffers are read ahead at the next column address (col_d)
  lsh_line_buf #(.Depth(MaxWidth), .AddrW(CW)) u_upper (
    .clk_i   (clk_i),
    .we_i    (accept_i),
    .waddr_i (col_q),
    .wdata_i (mid),
    .raddr_i (col_d),
    .rdata_o (up_rd)
  );

  lsh_line_buf #(.Depth(MaxWidth), .AddrW(CW)) u_middle (
    .clk_i   (clk_i),
    .we_i    (accept_i),
    .waddr_i (col_q),
    .wdata_i (px),
    .raddr_i (col_d),
    .rdata_o (mid_rd)
  );

  // Reduce the eight neighbours of each channel to one sum
  always_comb begin
    taps_o.emit = emit;
    taps_o.last = last;
    for (int ch = 0; ch < NCH; ch++) begin
      taps_o.ctr[ch]  = ctr_q[1][CH_W*ch +: CH_W];
      taps_o.nsum[ch] = SUM_W'(left_q[0][CH_W*ch +: CH_W]) +
                        SUM_W'(left_q[1][CH_W*ch +: CH_W]) +
                        SUM_W'(left_q[2][CH_W*ch +: CH_W]) +
                        SUM_W'(ctr_q[0][CH_W*ch +: CH_W]) +
                        SUM_W'(ctr_q[2][CH_W*ch +: CH_W]) +
                        SUM_W'(right[0][CH_W*ch +: CH_W]) +
                        SUM_W'(right[1][CH_W*ch +: CH_W]) +
                        SUM_W'(right[2][CH_W*ch +: CH_W]);
    end
  end

  col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(col_q) < CNT_W'(MaxWidth))
    else $error("column counter beyond line buffer depth");

  frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last |=> (col_q == '0) && (row_q == '0) && (ctr_q == '0))
    else $error("frame end did not clear counters and window");

endmodule

// File: rtl/lsh_lane.sv
// One colour channel: weight multiply stage and signed difference with clamp.
// Depends on lsh_pkg for widths; control valids are kept by the top level.
module lsh_lane (
  input  logic                         clk_i,
  input  logic                         load1_i,
  input  logic                         load2_i,
  input  logic [lsh_pkg::SUM_W-1:0]    nsum_i,
  input  logic [lsh_pkg::CH_W-1:0]     ctr_i,
  input  logic [lsh_pkg::SIDE_W-1:0]   side_w_i,
  input  logic [lsh_pkg::CTRW_W-1:0]   ctr_w_i,
  output logic [lsh_pkg::CH_W-1:0]     pix_o
);
  import lsh_pkg::*;

  logic [SUM_W-1:0]  nsum1_q;
  logic [CH_W-1:0]   ctr1_q;
  logic [PROD_W-1:0] pos2_q, neg2_q;
  logic signed [PROD_W:0] diff;

  // Capture taps
  always_ff @(posedge clk_i) begin
    if (load1_i) begin
      nsum1_q <= nsum_i;
      ctr1_q  <= ctr_i;
    end
  end

  // Apply centre and surround weights
  always_ff @(posedge clk_i) begin
    if (load2_i) begin
      pos2_q <= PROD_W'(ctr1_q) * PROD_W'(ctr_w_i);
      neg2_q <= PROD_W'(nsum1_q) * PROD_W'(side_w_i);
    end
  end

  // Subtract and clamp to the pixel range
  always_comb begin
    diff = $signed({1'b0, pos2_q}) - $signed({1'b0, neg2_q});
    if (diff < 0) begin
      pix_o = '0;
    end else if (diff > $signed((PROD_W + 1)'(255))) begin
      pix_o = '1;
    end else begin
      pix_o = diff[CH_W-1:0];
    end
  end

endmodule

// File: rtl/lsh_merge.sv
// Output register: joins the three lane results and the frame-end flag into one item.
// Depends on lsh_pkg; gives the pipeline its advance condition.
module lsh_merge (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic                                 last_i,
  input  logic [lsh_pkg::NCH-1:0][lsh_pkg::CH_W-1:0] pix_i,
  output logic                                 ready_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [lsh_pkg::CH_W-1:0]             out_blue_o,
  output logic [lsh_pkg::CH_W-1:0]             out_green_o,
  output logic [lsh_pkg::CH_W-1:0]             out_red_o,
  output logic                                 frame_end_o
);
  import lsh_pkg::*;

  logic                      valid_q;
  logic                      last_q;
  logic [NCH-1:0][CH_W-1:0]  pix_q;

  assign ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Hold payload while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      last_q <= last_i;
      pix_q  <= pix_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_blue_o  = pix_q[0];
  assign out_green_o = pix_q[1];
  assign out_red_o   = pix_q[2];
  assign frame_end_o = last_q;

endmodule

// File: rtl/laplacian_sharpen_3x3_top.sv
// Top level of the 3x3 Laplacian sharpening filter for raster RGB pixels.
// Depends on lsh_pkg, lsh_window, lsh_lane and lsh_merge.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one RGB pixel per item in
//   raster order, plus drain_i for padding items. After each frame send
//   width+1 drain items to flush the last row.
//   Output channel (out_valid_o/out_ready_i) carries one filtered pixel per
//   item; frame_end_o marks the bottom-right pixel of the frame.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 width, 1 height, 2 strength) in the same cycle; write only when idle.
// Throughput: one item per clock unless the output stalls, set by the single
//   line-buffer write and read port per cycle and three parallel lanes.
// Path: the result for pixel (r,c) is completed by input item r*W+c+W+1
//   and passes through the window/sum stage, the multiply stage and the
//   output register, in that order, before it appears on the output.
// Reset: counters and window clear, width 1024, height 682, strength 9.
//   Line buffers are not cleared; rows not yet written are masked out.
// Stall: stages keep moving into empty slots; in_ready_o drops only when
//   the output register and both inner stages are full.
module laplacian_sharpen_3x3_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [lsh_pkg::CH_W-1:0]        in_blue_i,
  input  logic [lsh_pkg::CH_W-1:0]        in_green_i,
  input  logic [lsh_pkg::CH_W-1:0]        in_red_i,
  input  logic                            drain_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [lsh_pkg::CH_W-1:0]        out_blue_o,
  output logic [lsh_pkg::CH_W-1:0]        out_green_o,
  output logic [lsh_pkg::CH_W-1:0]        out_red_o,
  output logic                            frame_end_o,
  input  logic                            cfg_we_i,
  input  logic [lsh_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lsh_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import lsh_pkg::*;

  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [SIDE_W-1:0]   side_w_q;
  logic [CTRW_W-1:0]   ctr_w_q;

  logic  accept, en1, en2, en3;
  logic  v1_q, v2_q, last1_q, last2_q;
  taps_t taps;
  logic [NCH-1:0][CH_W-1:0] lane_pix;

  // Configuration registers; strength is kept as its two weights
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      side_w_q <= side_weight(STR_RST);
      ctr_w_q  <= centre_weight(STR_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:    width_q  <= cfg_data_i[WIDTH_W-1:0];
        CFG_HEIGHT:   height_q <= cfg_data_i[HEIGHT_W-1:0];
        CFG_STRENGTH: begin
          side_w_q <= side_weight(cfg_data_i[STR_W-1:0]);
          ctr_w_q  <= centre_weight(cfg_data_i[STR_W-1:0]);
        end
        default: ;
      endcase
    end
  end

  // Stage advance: each stage moves when it is empty or the next one moves
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;
  assign accept     = in_valid_i && en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= accept && taps.emit;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      last1_q <= taps.last;
    end
    if (en2) begin
      last2_q <= last1_q;
    end
  end

  lsh_window #(.MaxWidth(MAX_WIDTH)) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_blue_i  (in_blue_i),
    .in_green_i (in_green_i),
    .in_red_i   (in_red_i),
    .drain_i    (drain_i),
    .width_i    (width_q),
    .height_i   (height_q),
    .taps_o     (taps)
  );

  // One lane per colour channel
  for (genvar ch = 0; ch < NCH; ch++) begin : g_lane
    lsh_lane u_lane (
      .clk_i    (clk_i),
      .load1_i  (en1),
      .load2_i  (en2),
      .nsum_i   (taps.nsum[ch]),
      .ctr_i    (taps.ctr[ch]),
      .side_w_i (side_w_q),
      .ctr_w_i  (ctr_w_q),
      .pix_o    (lane_pix[ch])
    );
  end

  lsh_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v2_q),
    .last_i      (last2_q),
    .pix_i       (lane_pix),
    .ready_o     (en3),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_blue_o  (out_blue_o),
    .out_green_o (out_green_o),
    .out_red_o   (out_red_o),
    .frame_end_o (frame_end_o)
  );

  stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && out_valid_o && !out_ready_i))
    else $error("input stalled while the pipeline has a free slot");

endmodule

// File: test/tb.sv
// Testbench for laplacian_sharpen_3x3_top: drives RGB pixel frames and drain items with
// random idling on both channels and checks every filtered pixel against a built-in predictor.
// Depends on lsh_pkg and the rtl of the sharpening block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsh_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int MODE_ITEMS    = 300;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic            frame_end;
  } sharp_px_t;

  // Predicts filtered pixels from accepted items and checks what comes out
  class sharpen_scoreboard;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [STR_W-1:0]    strength_reg;
    logic [PIX_W-1:0]    upper_row [MAX_W];
    logic [PIX_W-1:0]    middle_row [MAX_W];
    logic [PIX_W-1:0]    window [6];
    int unsigned         col;
    int unsigned         row;
    bit                  wrapped;
    sharp_px_t           pending_pixels [$];
    int unsigned         checked;
    int unsigned         mismatch_count;

    function new();
      width_reg      = WIDTH_RST;
      height_reg     = HEIGHT_RST;
      strength_reg   = STR_RST;
      col            = 0;
      row            = 0;
      wrapped        = 1'b0;
      checked        = 0;
      mismatch_count = 0;
      foreach (upper_row[i]) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_WIDTH:    width_reg    = data[WIDTH_W-1:0];
        CFG_HEIGHT:   height_reg   = data[HEIGHT_W-1:0];
        CFG_STRENGTH: strength_reg = data[STR_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_height();
      return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    // One channel: centre weight times centre minus surround weight times the ring
    function logic [CH_W-1:0] sharpen_channel(logic [8:0][PIX_W-1:0] taps, int sh);
      int side;
      int centre;
      int ring;
      int acc;
      side   = int'(strength_reg) / 9;
      centre = 1 + (8 * int'(strength_reg)) / 9;
      ring   = 0;
      for (int i = 0; i < 9; i++)
        if (i != 4) ring += int'(taps[i][sh +: CH_W]);
      acc = centre * int'(taps[4][sh +: CH_W]) - side * ring;
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
      return CH_W'(acc);
    endfunction

    function void take_pixel(logic [CH_W-1:0] blue, logic [CH_W-1:0] green,
                             logic [CH_W-1:0] red, logic drain);
      int unsigned           w;
      int unsigned           h;
      int unsigned           c;
      int unsigned           r;
      int unsigned           idx;
      logic [PIX_W-1:0]      px;
      logic [PIX_W-1:0]      up;
      logic [PIX_W-1:0]      mid;
      logic [8:0][PIX_W-1:0] taps;
      bit                    emit;
      bit                    last;
      sharp_px_t             res;
      w = width_reg;
      if (w == 0) w = 1;
      if (w > MAX_W) w = MAX_W;
      h   = eff_height();
      c   = col;
      r   = row;
      idx = (c < MAX_W) ? c : MAX_W - 1;
      px  = {red, green, blue};
      // zero padding items and anything past the last row
      if (drain || r >= h) px = '0;
      up  = (r >= 2) ? upper_row[idx] : '0;
      mid = (r >= 1) ? middle_row[idx] : '0;
      taps[0] = window[0]; taps[1] = window[3]; taps[2] = (c == 0) ? '0 : up;
      taps[3] = window[1]; taps[4] = window[4]; taps[5] = (c == 0) ? '0 : mid;
      taps[6] = window[2]; taps[7] = window[5]; taps[8] = (c == 0) ? '0 : px;
      emit = (r >= 2) || (r == 1 && c >= 1);
      last = (c == 0) && (r >= h + 1);
      if (emit) begin
        res.blue      = sharpen_channel(taps, 0);
        res.green     = sharpen_channel(taps, CH_W);
        res.red       = sharpen_channel(taps, 2 * CH_W);
        res.frame_end = last;
        pending_pixels.push_back(res);
      end
      // shift the window, clearing the left columns at the start of a row
      if (c == 0) begin
        window[0] = '0; window[1] = '0; window[2] = '0;
      end else begin
        window[0] = window[3]; window[1] = window[4]; window[2] = window[5];
      end
      window[3] = up;
      window[4] = mid;
      window[5] = px;
      upper_row[idx]  = mid;
      middle_row[idx] = px;
      // advance the raster position
      wrapped = last;
      if (last) begin
        col = 0;
        row = 0;
        foreach (window[i]) window[i] = '0;
      end else if (c + 1 >= w) begin
        col = 0;
        row = r + 1;
      end else begin
        col = c + 1;
      end
    endfunction

    task flag_mismatch(string msg);
      $display("[%0t] pixel %0d: %s", $time, checked, msg);
      mismatch_count++;
    endtask

    task check_pixel(sharp_px_t got);
      sharp_px_t want;
      if (pending_pixels.size() == 0) begin
        flag_mismatch($sformatf("unexpected output %h", got));
        checked++;
        return;
      end
      want = pending_pixels.pop_front();
      if (got.blue !== want.blue)
        flag_mismatch($sformatf("blue %0d, predicted %0d", got.blue, want.blue));
      if (got.green !== want.green)
        flag_mismatch($sformatf("green %0d, predicted %0d", got.green, want.green));
      if (got.red !== want.red)
        flag_mismatch($sformatf("red %0d, predicted %0d", got.red, want.red));
      if (got.frame_end !== want.frame_end)
        flag_mismatch($sformatf("frame_end %0b, predicted %0b", got.frame_end,
                                want.frame_end));
      checked++;
    endtask
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [CH_W-1:0]       in_blue_i   = '0;
  logic [CH_W-1:0]       in_green_i  = '0;
  logic [CH_W-1:0]       in_red_i    = '0;
  logic                  drain_i     = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [CH_W-1:0]       out_blue_o;
  logic [CH_W-1:0]       out_green_o;
  logic [CH_W-1:0]       out_red_o;
  logic                  frame_end_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  sharpen_scoreboard sb;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                sent_items    = 0;
  int                hold_tokens   = 0;
  int                hold_seen     = 0;
  int                hold_left     = 0;

  laplacian_sharpen_3x3_top #(
    .MAX_WIDTH (MAX_W)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_blue_i   (in_blue_i),
    .in_green_i  (in_green_i),
    .in_red_i    (in_red_i),
    .drain_i     (drain_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_blue_o  (out_blue_o),
    .out_green_o (out_green_o),
    .out_red_o   (out_red_o),
    .frame_end_o (frame_end_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin : clock_gen
    forever #6 clk_i = ~clk_i;
  end

  // Check results and drive the receiver's ready, with an occasional long hold-off
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      sb.check_pixel({out_blue_o, out_green_o, out_red_o, frame_end_o});
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_seen != hold_tokens) begin
      hold_seen   <= hold_tokens;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one item, idling first at random, and hold it until taken
  task automatic send_item(input logic [CH_W-1:0] blue, input logic [CH_W-1:0] green,
                           input logic [CH_W-1:0] red, input logic drain);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_blue_i  <= blue;
    in_green_i <= green;
    in_red_i   <= red;
    drain_i    <= drain;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_pixel(blue, green, red, drain);
    sent_items++;
  endtask

  // Drop valid and let every outstanding pixel drain out of the pipeline
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                          input logic [CFG_DATA_W-1:0] k);
    wait_idle();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_STRENGTH, k);
    cfg_we_i <= 1'b0;
  endtask

  // Stream one frame and its drain tail until the frame wraps, with some noise
  task automatic run_frame(input bit allow_change);
    int count;
    int change_at;
    count     = 0;
    change_at = (allow_change && $urandom_range(4) == 0) ? $urandom_range(1, 20) : -1;
    sb.wrapped = 1'b0;
    while (!sb.wrapped) begin
      if (count == change_at) begin
        // retune strength and height partway into the frame
        wait_idle();
        write_reg(CFG_STRENGTH, CFG_DATA_W'($urandom_range(63)));
        write_reg(CFG_HEIGHT, CFG_DATA_W'($urandom_range(6)));
        cfg_we_i <= 1'b0;
      end
      if (sb.row < sb.eff_height())
        send_item(8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(29) == 0);
      else if ($urandom_range(19) == 0)
        send_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
      else
        send_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
      count++;
    end
  endtask

  task automatic random_setup();
    logic [CFG_DATA_W-1:0] w;
    logic [CFG_DATA_W-1:0] k;
    case ($urandom_range(9))
      0:       w = '0;
      1:       w = CFG_DATA_W'($urandom_range(9, 40));
      default: w = CFG_DATA_W'($urandom_range(1, 8));
    endcase
    case ($urandom_range(5))
      0:       k = '0;
      1:       k = CFG_DATA_W'(63);
      default: k = CFG_DATA_W'($urandom_range(63));
    endcase
    set_regs(w, CFG_DATA_W'($urandom_range(6)), k);
  endtask

  initial begin : stimulus
    int start;
    sb = new();
    send_idle_pct = 7;
    recv_idle_pct = 86;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // strongest kernel on a 3x2 frame of extreme pixels
    set_regs(13'd3, 13'd2, 13'd63);
    send_item(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_item(8'h00, 8'h00, 8'h00, 1'b0);
    send_item(8'hAA, 8'h55, 8'hFF, 1'b0);
    send_item(8'h01, 8'h80, 8'h7F, 1'b0);
    send_item(8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_item(8'hFF, 8'h00, 8'hFF, 1'b0);
    // a real pixel past the last row is taken as zero
    send_item(8'hC3, 8'h3C, 8'h5A, 1'b0);
    repeat (3) send_item(8'hFF, 8'hFF, 8'hFF, 1'b1);

    // zero strength passes pixels through
    set_regs(13'd2, 13'd1, 13'd0);
    send_item(8'hFF, 8'h00, 8'h80, 1'b0);
    send_item(8'h7F, 8'hFE, 8'h01, 1'b0);
    repeat (3) send_item(8'h00, 8'h00, 8'h00, 1'b1);

    // zero width and zero height act as one
    set_regs(13'd0, 13'd0, 13'd9);
    send_item(8'hFF, 8'hFF, 8'hFF, 1'b0);
    repeat (2) send_item(8'h00, 8'h00, 8'h00, 1'b1);

    // random frames under three idling patterns
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      start = sent_items;
      while (sent_items - start < MODE_ITEMS) begin
        random_setup();
        run_frame(1'b1);
      end
    end

    // stall the receiver early in a mid-size frame to back up the input
    set_regs(13'd8, 13'd12, CFG_DATA_W'($urandom_range(63)));
    hold_tokens++;
    run_frame(1'b0);

    wait_idle();
    if (sb.mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
